// ===== hw/rtl/mbra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mbra_pkg;

  // Bitmap geometry
  localparam int unsigned MAX_WIDTH     = 256;
  localparam int unsigned MAX_HEIGHT    = 256;
  localparam int unsigned ROW_BYTES_MAX = (MAX_WIDTH + 7) / 8;
  localparam int unsigned STORE_DEPTH   = ROW_BYTES_MAX * MAX_HEIGHT;
  localparam int unsigned ADDR_W        = $clog2(STORE_DEPTH);
  localparam int unsigned STRIDE_W      = $clog2(ROW_BYTES_MAX + 1);

  // Field widths
  localparam int unsigned DIM_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BYTE_W    = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // Operation codes; codes 6 and 7 are ignored
  typedef enum logic [2:0] {
    OP_GET_PIXEL  = 3'd0,
    OP_SET_PIXEL  = 3'd1,
    OP_GET_BYTE   = 3'd2,
    OP_SET_BYTE   = 3'd3,
    OP_GET_RASTER = 3'd4,
    OP_SET_RUN    = 3'd5
  } mbra_op_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] x;
    logic [4:0] byte_column;
    logic [7:0] y;
    logic [7:0] value;
    logic [3:0] run_width;
  } mbra_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       in_range;
  } mbra_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_step;
    logic load;
    logic rd_lo;
    logic rd_hi;
    logic cap_lo;
    logic cap_hi;
    logic wr_lo;
    logic wr_hi;
    logic finish;
  } mbra_cmd_t;

  // Bit order swap between stored (LSB first) and raster (MSB first) bytes
  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mono_bitmap_raster_access_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                     Payload
// request   in         start && !busy                req_i (mbra_req_t)
// result    out        done_o, one-cycle strobe      rsp_o (mbra_rsp_t)
// config    in         cfg_we_i                      cfg_idx_i, cfg_wdata_i
//
// The result strobe follows the store sequence that starts at the acceptance
// edge: read low byte, read high byte, capture, write low byte, write high
// byte. busy drops as the strobe goes out; no new request is taken until then.
// After reset every byte of the store is swept to zero with busy high;
// configuration writes are taken during the sweep.
// The result is shown for one cycle only; the receiver cannot stall it.

module mono_bitmap_raster_access_top
  import mbra_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire mbra_req_t            req_i,
  output      logic                 done_o,
  output      mbra_rsp_t            rsp_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_wdata_i
);

  mbra_cmd_t cmd;
  logic      clr_last;

  mbra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .clr_last_i (clr_last),
    .busy_o     (busy),
    .cmd_o      (cmd)
  );

  mbra_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .clr_last_o  (clr_last),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mbra_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mbra_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbra_ctrl
  import mbra_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire logic      clr_last_i,
  output      logic      busy_o,
  output      mbra_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_RD_LO = 7'b0000100,
    ST_RD_HI = 7'b0001000,
    ST_CAPT  = 7'b0010000,
    ST_WR_LO = 7'b0100000,
    ST_WR_HI = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Sequencing and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (clr_last_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RD_LO;
        end
      end
      ST_RD_LO: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = ST_RD_HI;
      end
      ST_RD_HI: begin
        cmd_o.rd_hi  = 1'b1;
        cmd_o.cap_lo = 1'b1;
        state_d      = ST_CAPT;
      end
      ST_CAPT: begin
        cmd_o.cap_hi = 1'b1;
        state_d      = ST_WR_LO;
      end
      ST_WR_LO: begin
        cmd_o.wr_lo = 1'b1;
        state_d     = ST_WR_HI;
      end
      ST_WR_HI: begin
        cmd_o.wr_hi  = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Clear pass runs only right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
    else $error("clear pass re-entered");

  // An accepted transaction always walks from the low read through the high read to capture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_LO) |=> (state_q == ST_RD_HI) ##1 (state_q == ST_CAPT))
    else $error("access sequence broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !busy_o)
    else $error("load while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/mbra_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbra_dp
  import mbra_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mbra_cmd_t            cmd_i,
  input  wire mbra_req_t            req_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DIM_W-1:0]     cfg_wdata_i,
  output      logic                 clr_last_o,
  output      logic                 done_o,
  output      mbra_rsp_t            rsp_o
);

  localparam int unsigned ROWB_W = STRIDE_W + 8;

  logic [DIM_W-1:0]  cfg_width_q, cfg_height_q;
  logic [ADDR_W-1:0] clr_addr_q;
  mbra_req_t         req_q;
  logic [ADDR_W-1:0] addr_lo_q;
  logic              ok_q, wlo_q, whi_q, hi_ok_q;
  logic [7:0]        lo_q, hi_q;
  logic              done_q;
  mbra_rsp_t         rsp_q;

  // Store port signals
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr, addr_hi;
  logic [7:0]        ram_wdata, ram_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= DIM_W'(MAX_WIDTH);
      cfg_height_q <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  cfg_width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: cfg_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [DIM_W-1:0]    eff_w, eff_h;
  logic [DIM_W:0]      stride_sum;
  logic [STRIDE_W-1:0] stride;
  assign eff_w      = (cfg_width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_width_q;
  assign eff_h      = (cfg_height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_height_q;
  assign stride_sum = {1'b0, eff_w} + (DIM_W + 1)'(7);
  assign stride     = stride_sum[3 +: STRIDE_W];

  // Range checks and address of the first byte
  logic [4:0]          s_col;
  logic [2:0]          b_off;
  logic                x_in, y_in, col_in, hi_ok, run_ok, fits, byte_op;
  logic [DIM_W:0]      x_end;
  logic [15:0]         run_mask, mask16;
  logic [4:0]          col_sel;
  logic [ROWB_W-1:0]   row_base;
  logic [ADDR_W-1:0]   addr_lo_d;
  logic                ok_d, wlo_d, whi_d;

  assign s_col    = req_q.x[7:3];
  assign b_off    = req_q.x[2:0];
  assign x_in     = ({1'b0, req_q.x} < eff_w);
  assign y_in     = ({1'b0, req_q.y} < eff_h);
  assign col_in   = ({1'b0, req_q.byte_column} < stride);
  assign hi_ok    = (({1'b0, s_col} + STRIDE_W'(1)) < stride);
  assign run_ok   = (req_q.run_width >= 4'd1) && (req_q.run_width <= 4'd8);
  assign x_end    = {2'b00, req_q.x} + {6'b000000, req_q.run_width};
  assign fits     = (b_off == 3'd0) ? ({1'b0, s_col} < stride) : (x_end <= {1'b0, eff_w});
  assign run_mask = (16'd1 << req_q.run_width) - 16'd1;
  assign mask16   = run_mask << b_off;
  assign byte_op  = (req_q.operation == OP_GET_BYTE) || (req_q.operation == OP_SET_BYTE);
  assign col_sel  = byte_op ? req_q.byte_column : s_col;
  assign row_base = ROWB_W'(stride) * ROWB_W'(req_q.y);
  assign addr_lo_d = ADDR_W'(row_base + ROWB_W'(col_sel));

  // Operation decode
  always_comb begin
    ok_d  = 1'b0;
    wlo_d = 1'b0;
    whi_d = 1'b0;
    unique case (req_q.operation) inside
      OP_GET_PIXEL, OP_GET_RASTER: begin
        ok_d = x_in && y_in;
      end
      OP_SET_PIXEL: begin
        ok_d  = x_in && y_in;
        wlo_d = ok_d;
      end
      OP_GET_BYTE: begin
        ok_d = col_in && y_in;
      end
      OP_SET_BYTE: begin
        ok_d  = col_in && y_in;
        wlo_d = ok_d;
      end
      OP_SET_RUN: begin
        ok_d  = run_ok && y_in && fits;
        wlo_d = ok_d;
        whi_d = ok_d && (mask16[15:8] != 8'd0) && hi_ok;
      end
      default: ;
    endcase
  end

  // Request and check registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.rd_lo) begin
      addr_lo_q <= addr_lo_d;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= ram_rdata;
    end
    if (cmd_i.cap_hi) begin
      hi_q <= ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q    <= 1'b0;
      wlo_q   <= 1'b0;
      whi_q   <= 1'b0;
      hi_ok_q <= 1'b0;
    end else if (cmd_i.rd_lo) begin
      ok_q    <= ok_d;
      wlo_q   <= wlo_d;
      whi_q   <= whi_d;
      hi_ok_q <= hi_ok;
    end
  end

  // Merge and read-out from the two captured bytes
  logic [15:0] win, run_data;
  logic [7:0]  pix_bit, new_lo, new_hi, rd_val;
  assign win      = {(hi_ok_q ? hi_q : 8'd0), lo_q};
  assign pix_bit  = 8'd1 << b_off;
  assign run_data = ({8'd0, reverse8(req_q.value)} << b_off) & mask16;

  always_comb begin
    new_lo = lo_q;
    new_hi = hi_q;
    rd_val = 8'd0;
    unique case (req_q.operation)
      OP_GET_PIXEL:  rd_val = {7'd0, lo_q[b_off]};
      OP_SET_PIXEL:  new_lo = (req_q.value != 8'd0) ? (lo_q | pix_bit) : (lo_q & ~pix_bit);
      OP_GET_BYTE:   rd_val = lo_q;
      OP_SET_BYTE:   new_lo = req_q.value;
      OP_GET_RASTER: rd_val = reverse8(win[b_off +: 8]);
      OP_SET_RUN: begin
        new_lo = (lo_q & ~mask16[7:0]) | run_data[7:0];
        new_hi = (hi_q & ~mask16[15:8]) | run_data[15:8];
      end
      default: ;
    endcase
  end

  // Store port
  assign addr_hi   = addr_lo_q + ADDR_W'(1);
  assign ram_we    = cmd_i.clr_step || (cmd_i.wr_lo && wlo_q) || (cmd_i.wr_hi && whi_q);
  assign ram_waddr = cmd_i.clr_step ? clr_addr_q : (cmd_i.wr_hi ? addr_hi : addr_lo_q);
  assign ram_wdata = cmd_i.clr_step ? 8'd0 : (cmd_i.wr_hi ? new_hi : new_lo);
  assign ram_raddr = cmd_i.rd_hi ? addr_hi : addr_lo_d;

  mbra_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
    end
  end
  assign clr_last_o = (clr_addr_q == ADDR_W'(STORE_DEPTH - 1));

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_q.read_data <= ok_q ? rd_val : 8'd0;
      rsp_q.in_range  <= ok_q;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held two cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !rsp_q.in_range) |-> (rsp_q.read_data == 8'd0))
    else $error("data returned for skipped access");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_hi && whi_q) |-> (wlo_q && ok_q && (req_q.operation == OP_SET_RUN)))
    else $error("second byte written outside a run write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_hi && whi_q) |-> (ram_waddr == ($past(ram_waddr) + ADDR_W'(1))))
    else $error("second byte not adjacent to first");

endmodule

`default_nettype wire
